// ----- rtl/core/utf8v_pkg.sv -----
// Package for the UTF-8 text validator: widths, reset values, register
// indexes and the structs passed between the core and its decode stage.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utf8v_pkg;

  localparam int unsigned LenW = 14;
  localparam int unsigned CodeW = 21;

  localparam logic [LenW-1:0] CountCap = 14'd8193;
  localparam logic [LenW-1:0] MinLenRst = 14'd0;
  localparam logic [LenW-1:0] MaxLenRst = 14'd128;

  typedef enum logic [0:0] {
    CfgMinLen = 1'b0,
    CfgMaxLen = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } utf8v_word_t;

  typedef struct packed {
    logic            failed;
    logic [1:0]      pend;
    logic [1:0]      seq_len;
    logic [CodeW-1:0] acc;
    logic [LenW-1:0] count;
  } utf8v_state_t;

  typedef struct packed {
    logic            text_ok;
    logic [LenW-1:0] byte_count;
  } utf8v_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/utf8v_in_if.sv -----
// Input channel of the UTF-8 text validator: one word per string byte.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last;

  modport source (output valid, output data_byte, output byte_present, output last,
                  input ready);
  modport sink (input valid, input data_byte, input byte_present, input last,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/utf8v_out_if.sv -----
// Result channel of the UTF-8 text validator: one word per string verdict.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface utf8v_out_if;
  logic        valid;
  logic        ready;
  logic        text_ok;
  logic [13:0] byte_count;

  modport source (output valid, output text_ok, output byte_count, input ready);
  modport sink (input valid, input text_ok, input byte_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/utf8v_decode.sv -----
// Single-byte decode step: next string state and the verdict for a word.
// Depends on utf8v_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8v_decode (
  input  utf8v_pkg::utf8v_state_t  state_i,
  input  utf8v_pkg::utf8v_word_t   word_i,
  input  logic [13:0]              min_len_i,
  input  logic [13:0]              max_len_i,
  output utf8v_pkg::utf8v_state_t  state_o,
  output utf8v_pkg::utf8v_result_t result_o
);
  import utf8v_pkg::*;

  utf8v_state_t     st;
  logic [CodeW-1:0] acc_new;
  logic [1:0]       pend_new;
  logic             reject;
  logic [7:0]       b;

  assign b = word_i.data_byte;
  assign acc_new = {state_i.acc[CodeW-7:0], b[5:0]};
  assign pend_new = state_i.pend - 2'd1;

  always_comb begin
    reject = 1'b0;
    case (state_i.seq_len)
      2'd1: reject = (acc_new < 21'h000080);
      2'd2: reject = (acc_new < 21'h000800);
      2'd3: reject = (acc_new < 21'h010000);
      default: reject = 1'b0;
    endcase
    if (acc_new > 21'h10FFFF) reject = 1'b1;
    if (acc_new inside {[21'h00D800:21'h00DFFF], [21'h000080:21'h00009F]}) reject = 1'b1;
  end

  always_comb begin
    st = state_i;
    if (word_i.byte_present) begin
      if (state_i.count < CountCap) st.count = state_i.count + 14'd1;
      if (!state_i.failed) begin
        if (state_i.pend == 2'd0) begin
          if (!b[7]) begin
            if (b inside {[8'h00:8'h1F], 8'h7F}) st.failed = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            st.acc = {16'd0, b[4:0]};
            st.pend = 2'd1;
            st.seq_len = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            st.acc = {17'd0, b[3:0]};
            st.pend = 2'd2;
            st.seq_len = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            st.acc = {18'd0, b[2:0]};
            st.pend = 2'd3;
            st.seq_len = 2'd3;
          end else begin
            st.failed = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          st.failed = 1'b1;
          st.pend = 2'd0;
        end else begin
          st.acc = acc_new;
          st.pend = pend_new;
          if (pend_new == 2'd0) begin
            st.failed = reject;
            st.seq_len = 2'd0;
            st.acc = '0;
          end
        end
      end
    end

    result_o.text_ok = !st.failed && (st.pend == 2'd0) &&
                       (st.count >= min_len_i) && (st.count <= max_len_i);
    result_o.byte_count = st.count;

    state_o = st;
    if (word_i.last) state_o = '0;
  end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_text_validator_core.sv -----
// UTF-8 text validator top level: input register, string state, result register.
// Depends on utf8v_pkg, utf8v_in_if, utf8v_out_if and utf8v_decode.
//
// Usage: each word on in_if carries one byte of a string (byte_present = 1)
// or none (byte_present = 0); last = 1 closes the string and yields exactly
// one word on out_if: text_ok and the saturated byte_count (max 8193).
// A word with no byte and last = 0 has no effect. An empty string is a
// single word with byte_present = 0 and last = 1.
// Path: a closing word is taken into the input register, then decoded with
// the string state, and its verdict is written to the result register.
// Throughput: one word per cycle while no result is held back on out_if; the
// limit is the one-byte decode step that updates the string state register.
// Stall: while out_if.ready is low with a result held, one more word is
// held in the input register and in_if.ready then drops.
// Reset: asynchronous, active low; clears the string state, empties both
// registers and sets min_length to 0 and max_length to 128.
// cfg_we_i writes cfg_wdata_i to register cfg_idx_i (min, then max).
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_validator_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  utf8v_pkg::cfg_idx_e cfg_idx_i,
  input  logic [13:0]         cfg_wdata_i,
  utf8v_in_if.sink            in_if,
  utf8v_out_if.source         out_if
);
  import utf8v_pkg::*;

  logic [LenW-1:0] min_len_q, max_len_q;
  logic            in_vld_q;
  utf8v_word_t     in_q;
  utf8v_state_t    state_q, state_d;
  logic            out_vld_q, out_vld_d;
  utf8v_result_t   out_q, res;
  logic            advance;
  logic            in_take;

  assign advance = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || advance;
  assign in_take = in_if.valid && in_if.ready;

  utf8v_decode u_decode (
    .state_i   (state_q),
    .word_i    (in_q),
    .min_len_i (min_len_q),
    .max_len_i (max_len_q),
    .state_o   (state_d),
    .result_o  (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_if.ready) out_vld_d = 1'b0;
    if (advance && in_q.last) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenRst;
      max_len_q <= MaxLenRst;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMinLen: min_len_q <= cfg_wdata_i;
          CfgMaxLen: max_len_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_take) in_vld_q <= 1'b1;
      else if (advance) in_vld_q <= 1'b0;
      if (advance) state_q <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.data_byte    <= in_if.data_byte;
      in_q.byte_present <= in_if.byte_present;
      in_q.last         <= in_if.last;
    end
    if (advance && in_q.last) out_q <= res;
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.text_ok    = out_q.text_ok;
  assign out_if.byte_count = out_q.byte_count;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.count <= CountCap)
    else $error("byte count beyond cap");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!state_q.failed && state_q.pend == 2'd0) |-> (state_q.seq_len == 2'd0 &&
    state_q.acc == '0))
    else $error("sequence state left over outside a sequence");

  a_pend_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!state_q.failed && state_q.pend != 2'd0) |-> (state_q.seq_len >= state_q.pend))
    else $error("more continuations pending than sequence length");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.last) |=> (state_q == '0 && out_vld_q))
    else $error("string state not cleared after verdict");

endmodule

`default_nettype wire
